// File: design/rsmp2_pkg.sv
// Shared constants, coefficient ROM and state type of the 2x polyphase resampler.
package rsmp2_pkg;

   localparam int ROM_BITS     = 24;
   localparam int ROM_HALF     = 32;
   localparam int ROM_IDX_BITS = 6;
   localparam int DIGIT_BITS   = 8;

   localparam logic CMD_DECIM  = 1'b0;
   localparam logic CMD_INTERP = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_MAC,
      ST_DRAIN,
      ST_OUT
   } state_type;

   // Half of the symmetric low-pass, Q0.23; the last entry is the center tap.
   localparam logic signed [ROM_BITS-1:0] TAP_ROM [0:ROM_HALF] = '{
      -24'sd429,     24'sd252,      24'sd1654,     24'sd667,
      -24'sd3293,    -24'sd3805,    24'sd3691,     24'sd9539,
      24'sd0,        -24'sd16090,   -24'sd10563,   24'sd18702,
      24'sd28352,    -24'sd10385,   -24'sd48752,   -24'sd15216,
      24'sd61001,    24'sd59349,    -24'sd49785,   -24'sd113716,
      24'sd0,        24'sd158153,   24'sd96581,    -24'sd161582,
      -24'sd235366,  24'sd84402,    24'sd396745,   24'sd127647,
      -24'sd549460,  -24'sd611646,  24'sd659122,   24'sd2570964,
      24'sd3495143
   };

endpackage

// File: design/rsmp2_if.sv
// Valid/ready channel interfaces for the resampler request and response streams.
interface rsmp2_req_if #(
   parameter int SAMPLE_BITS = 24
) ();
   logic                          valid;
   logic                          ready;
   logic                          cmd;
   logic signed [SAMPLE_BITS-1:0] sample_in;

   modport source (output valid, output cmd, output sample_in, input ready);
   modport sink   (input valid, input cmd, input sample_in, output ready);
endinterface

interface rsmp2_rsp_if #(
   parameter int SAMPLE_BITS = 24
) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_out;
   logic                          from_interpolator;
   logic                          poly_phase;
   logic                          last;

   modport source (output valid, output sample_out, output from_interpolator,
                   output poly_phase, output last, input ready);
   modport sink   (input valid, input sample_out, input from_interpolator,
                   input poly_phase, input last, output ready);
endinterface

// File: design/polyphase_resampler_by_two.sv
// Top level: 2:1 decimator and 1:2 interpolator sharing one symmetric FIR ROM.
//
// Request channel (req_if): cmd 0 stores sample_in in the decimator history,
// cmd 1 stores it in the interpolator history. Every second decimator
// transaction produces one response; every interpolator transaction produces
// two (even-tap phase, then odd-tap phase, the second marked last).
// Response channel (rsp_if): saturated sample plus path/phase/last flags.
// One folded multiply-accumulate walks the taps, one coefficient digit at a
// time (fed MSB-first in 8-bit digits, NDIG = ceil(COEF_BITS/8) per tap).
// The first request of a decimator pair only writes the history; no other
// request is taken while a response is being computed. The next request is
// taken once the last response of the previous one has been loaded into the
// output register, even if it still sits there unread. If the receiver
// stalls, the output register holds and the engine waits before loading it.
// Reset (synchronous) empties both histories (unwritten entries read as zero
// through a per-ring wrap flag), clears ring pointers and the decimator phase.
module polyphase_resampler_by_two #(
   parameter int TAP_COUNT   = 65,
   parameter int SAMPLE_BITS = 24,
   parameter int COEF_BITS   = 24
) (
   input logic         clock,
   input logic         reset,
   rsmp2_req_if.sink   req_if,
   rsmp2_rsp_if.source rsp_if
);

   localparam int D        = rsmp2_pkg::DIGIT_BITS;
   localparam int TAP_W    = $clog2(TAP_COUNT);
   localparam int NDIG     = (COEF_BITS + D - 1) / D;
   localparam int COEF_PAD = NDIG * D;
   localparam int DIG_W    = (NDIG > 1) ? $clog2(NDIG) : 1;
   localparam int PROD_W   = SAMPLE_BITS + D + 1;
   localparam int PART_W   = SAMPLE_BITS + COEF_PAD + 1;
   localparam int ACC_W    = SAMPLE_BITS + COEF_BITS + 7;
   localparam int DIST_W   = (TAP_W + 2 > rsmp2_pkg::ROM_IDX_BITS + 1) ?
                             TAP_W + 2 : rsmp2_pkg::ROM_IDX_BITS + 1;
   localparam int SHL      = (COEF_BITS >= rsmp2_pkg::ROM_BITS) ?
                             COEF_BITS - rsmp2_pkg::ROM_BITS : 0;
   localparam int SHR      = (COEF_BITS < rsmp2_pkg::ROM_BITS) ?
                             rsmp2_pkg::ROM_BITS - COEF_BITS : 0;
   localparam int CW_W     = rsmp2_pkg::ROM_BITS + 9;

   localparam logic signed [CW_W-1:0]  COEF_HALF  = (CW_W'(1) << SHR) >> 1;
   localparam logic signed [ACC_W-1:0] RND_DECIM  = ACC_W'(1) << (COEF_BITS - 2);
   localparam logic signed [ACC_W-1:0] RND_INTERP = ACC_W'(1) << (COEF_BITS - 3);
   localparam logic signed [ACC_W-1:0] SAT_HI     =
      {{(ACC_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
   localparam logic signed [ACC_W-1:0] SAT_LO     = ~SAT_HI;
   localparam logic [TAP_W-1:0]  LAST_POS  = TAP_W'(TAP_COUNT - 1);
   localparam logic [TAP_W-1:0]  LAST_EVEN = TAP_W'((TAP_COUNT - 1) / 2);
   localparam logic [TAP_W-1:0]  LAST_ODD  = TAP_W'((TAP_COUNT - 2) / 2);
   localparam logic [DIST_W-1:0] MID2      = DIST_W'(TAP_COUNT - 1);
   localparam logic [DIG_W-1:0]  LAST_DIG  = DIG_W'(NDIG - 1);

   rsmp2_pkg::state_type state_ff, state_in;

   logic                          path_ff, path_in;
   logic                          phase_ff, phase_in;
   logic                          decim_phase_ff, decim_phase_in;
   logic [TAP_W-1:0]              dwpos_ff, dwpos_in;
   logic [TAP_W-1:0]              iwpos_ff, iwpos_in;
   logic                          dwrap_ff, dwrap_in;
   logic                          iwrap_ff, iwrap_in;
   logic [TAP_W-1:0]              newest_ff, newest_in;
   logic [TAP_W-1:0]              age_ff, age_in;
   logic [TAP_W-1:0]              rd_idx_ff, rd_idx_in;
   logic [DIG_W-1:0]              digit_ff, digit_in;
   logic                          samp_valid_ff, samp_valid_in;
   logic                          part_done_ff, part_done_in;
   logic [COEF_PAD-1:0]           coef_sr_ff, coef_sr_in;
   logic signed [PART_W-1:0]      part_ff, part_in;
   logic signed [ACC_W-1:0]       acc_ff, acc_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_ff, rsp_sample_in;
   logic                          rsp_interp_ff, rsp_interp_in;
   logic                          rsp_phase_ff, rsp_phase_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic                          wr_dec, wr_int;
   logic [TAP_W-1:0]              wr_addr;
   logic                          rd_en;
   logic [TAP_W-1:0]              rd_addr;
   logic                          rd_valid;
   logic [SAMPLE_BITS-1:0]        dq, iq;
   logic signed [SAMPLE_BITS-1:0] samp;
   logic [D-1:0]                  top_digit;
   logic signed [D:0]             digit_ext;
   logic signed [PROD_W-1:0]      prod;
   logic                          last_digit, last_tap;
   logic [TAP_W-1:0]              last_age;

   logic [TAP_W-1:0]                       age_sel;
   logic [TAP_W:0]                         tap_idx;
   logic [DIST_W-1:0]                      twice, tap_dist;
   logic [rsmp2_pkg::ROM_IDX_BITS-1:0]     rom_idx;
   logic signed [rsmp2_pkg::ROM_BITS-1:0]  rom_val;
   logic signed [CW_W-1:0]                 coef_wide;
   logic [COEF_PAD-1:0]                    coef_next;
   logic signed [ACC_W-1:0]                res;
   logic signed [ACC_W-1:0]                res_sat;

   // History rings
   rsmp2_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(TAP_COUNT)) u_decim_ring (
      .clock   (clock),
      .wr_en   (wr_dec),
      .wr_addr (wr_addr),
      .wr_data (req_if.sample_in),
      .rd_en   (rd_en && (path_ff == rsmp2_pkg::CMD_DECIM)),
      .rd_addr (rd_addr),
      .rd_data (dq)
   );

   rsmp2_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(TAP_COUNT)) u_interp_ring (
      .clock   (clock),
      .wr_en   (wr_int),
      .wr_addr (wr_addr),
      .wr_data (req_if.sample_in),
      .rd_en   (rd_en && (path_ff == rsmp2_pkg::CMD_INTERP)),
      .rd_addr (rd_addr),
      .rd_data (iq)
   );

   // Coefficient of the tap about to start
   always_comb begin
      age_sel = (state_ff == rsmp2_pkg::ST_FETCH) ? '0 : age_ff + TAP_W'(1);
      tap_idx = (path_ff == rsmp2_pkg::CMD_INTERP) ? {age_sel, phase_ff} : {1'b0, age_sel};
      twice   = DIST_W'({tap_idx, 1'b0});
      if (twice >= MID2) begin
         tap_dist = (twice - MID2) >> 1;
      end else begin
         tap_dist = (MID2 - twice) >> 1;
      end
      rom_idx = rsmp2_pkg::ROM_IDX_BITS'(DIST_W'(rsmp2_pkg::ROM_HALF) - tap_dist);
      if (tap_dist > DIST_W'(rsmp2_pkg::ROM_HALF)) begin
         rom_val = '0;
      end else begin
         rom_val = rsmp2_pkg::TAP_ROM[rom_idx];
      end
      // scale Q0.23 to COEF_BITS, rounding half up when narrowing
      coef_wide = ((CW_W'(rom_val) + COEF_HALF) >>> SHR) <<< SHL;
      coef_next = coef_wide[COEF_PAD-1:0];
   end

   // Digit-serial multiply: coefficient MSB digit first, top digit signed
   always_comb begin
      samp = samp_valid_ff ?
             $signed((path_ff == rsmp2_pkg::CMD_INTERP) ? iq : dq) : '0;
      top_digit = coef_sr_ff[COEF_PAD-1 -: D];
      digit_ext = $signed({(digit_ff == '0) ? top_digit[D-1] : 1'b0, top_digit});
      prod      = samp * digit_ext;
      last_digit = (digit_ff == LAST_DIG);
      if (path_ff == rsmp2_pkg::CMD_DECIM) begin
         last_age = LAST_POS;
      end else begin
         last_age = phase_ff ? LAST_ODD : LAST_EVEN;
      end
      last_tap = (age_ff == last_age);
   end

   // Rounding constant was preloaded into the accumulator
   always_comb begin
      res = (path_ff == rsmp2_pkg::CMD_INTERP) ? (acc_ff >>> (COEF_BITS - 2)) :
                                                 (acc_ff >>> (COEF_BITS - 1));
      priority if (res > SAT_HI) begin
         res_sat = SAT_HI;
      end else if (res < SAT_LO) begin
         res_sat = SAT_LO;
      end else begin
         res_sat = res;
      end
   end

   always_comb begin
      state_in       = state_ff;
      path_in        = path_ff;
      phase_in       = phase_ff;
      decim_phase_in = decim_phase_ff;
      dwpos_in       = dwpos_ff;
      iwpos_in       = iwpos_ff;
      dwrap_in       = dwrap_ff;
      iwrap_in       = iwrap_ff;
      newest_in      = newest_ff;
      age_in         = age_ff;
      rd_idx_in      = rd_idx_ff;
      digit_in       = digit_ff;
      samp_valid_in  = samp_valid_ff;
      part_done_in   = part_done_ff;
      coef_sr_in     = coef_sr_ff;
      part_in        = part_ff;
      acc_in         = acc_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;
      rsp_sample_in  = rsp_sample_ff;
      rsp_interp_in  = rsp_interp_ff;
      rsp_phase_in   = rsp_phase_ff;
      rsp_last_in    = rsp_last_ff;
      wr_dec         = 1'b0;
      wr_int         = 1'b0;
      wr_addr        = (req_if.cmd == rsmp2_pkg::CMD_INTERP) ? iwpos_ff : dwpos_ff;
      rd_en          = 1'b0;
      rd_addr        = rd_idx_ff;
      req_if.ready   = (state_ff == rsmp2_pkg::ST_IDLE);

      unique case (state_ff)
         rsmp2_pkg::ST_IDLE: begin
            if (req_if.valid) begin
               path_in   = req_if.cmd;
               phase_in  = 1'b0;
               newest_in = wr_addr;
               if (req_if.cmd == rsmp2_pkg::CMD_INTERP) begin
                  wr_int   = 1'b1;
                  iwpos_in = (iwpos_ff == LAST_POS) ? '0 : iwpos_ff + TAP_W'(1);
                  iwrap_in = iwrap_ff || (iwpos_ff == LAST_POS);
                  state_in = rsmp2_pkg::ST_FETCH;
               end else begin
                  wr_dec         = 1'b1;
                  dwpos_in       = (dwpos_ff == LAST_POS) ? '0 : dwpos_ff + TAP_W'(1);
                  dwrap_in       = dwrap_ff || (dwpos_ff == LAST_POS);
                  decim_phase_in = !decim_phase_ff;
                  if (decim_phase_ff) begin
                     state_in = rsmp2_pkg::ST_FETCH;
                  end
               end
            end
         end
         rsmp2_pkg::ST_FETCH: begin
            rd_en         = 1'b1;
            rd_addr       = newest_ff;
            rd_idx_in     = newest_ff;
            samp_valid_in = rd_valid;
            age_in        = '0;
            digit_in      = '0;
            coef_sr_in    = coef_next;
            part_done_in  = 1'b0;
            acc_in        = (path_ff == rsmp2_pkg::CMD_INTERP) ? RND_INTERP : RND_DECIM;
            state_in      = rsmp2_pkg::ST_MAC;
         end
         rsmp2_pkg::ST_MAC: begin
            part_in      = ((digit_ff == '0) ? '0 : (part_ff <<< D)) + PART_W'(prod);
            coef_sr_in   = coef_sr_ff << D;
            digit_in     = digit_ff + DIG_W'(1);
            part_done_in = last_digit;
            if (part_done_ff) begin
               acc_in = acc_ff + ACC_W'(part_ff);
            end
            if (last_digit) begin
               digit_in = '0;
               if (last_tap) begin
                  state_in = rsmp2_pkg::ST_DRAIN;
               end else begin
                  age_in        = age_ff + TAP_W'(1);
                  rd_en         = 1'b1;
                  rd_addr       = (rd_idx_ff == '0) ? LAST_POS : rd_idx_ff - TAP_W'(1);
                  rd_idx_in     = rd_addr;
                  samp_valid_in = rd_valid;
                  coef_sr_in    = coef_next;
               end
            end
         end
         rsmp2_pkg::ST_DRAIN: begin
            acc_in       = acc_ff + ACC_W'(part_ff);
            part_done_in = 1'b0;
            state_in     = rsmp2_pkg::ST_OUT;
         end
         rsmp2_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = res_sat[SAMPLE_BITS-1:0];
               rsp_interp_in = path_ff;
               rsp_phase_in  = phase_ff;
               rsp_last_in   = (path_ff == rsmp2_pkg::CMD_DECIM) || phase_ff;
               if ((path_ff == rsmp2_pkg::CMD_INTERP) && !phase_ff) begin
                  phase_in = 1'b1;
                  state_in = rsmp2_pkg::ST_FETCH;
               end else begin
                  state_in = rsmp2_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = rsmp2_pkg::ST_IDLE;
         end
      endcase
   end

   // Entries never written since reset read as zero
   assign rd_valid = ((path_ff == rsmp2_pkg::CMD_INTERP) ? iwrap_ff : dwrap_ff) ||
                     (rd_addr <= newest_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= rsmp2_pkg::ST_IDLE;
         decim_phase_ff <= 1'b0;
         dwpos_ff       <= '0;
         iwpos_ff       <= '0;
         dwrap_ff       <= 1'b0;
         iwrap_ff       <= 1'b0;
         part_done_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         decim_phase_ff <= decim_phase_in;
         dwpos_ff       <= dwpos_in;
         iwpos_ff       <= iwpos_in;
         dwrap_ff       <= dwrap_in;
         iwrap_ff       <= iwrap_in;
         part_done_ff   <= part_done_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      path_ff       <= path_in;
      phase_ff      <= phase_in;
      newest_ff     <= newest_in;
      age_ff        <= age_in;
      rd_idx_ff     <= rd_idx_in;
      digit_ff      <= digit_in;
      samp_valid_ff <= samp_valid_in;
      coef_sr_ff    <= coef_sr_in;
      part_ff       <= part_in;
      acc_ff        <= acc_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_interp_ff <= rsp_interp_in;
      rsp_phase_ff  <= rsp_phase_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_if.valid             = rsp_valid_ff;
   assign rsp_if.sample_out        = rsp_sample_ff;
   assign rsp_if.from_interpolator = rsp_interp_ff;
   assign rsp_if.poly_phase        = rsp_phase_ff;
   assign rsp_if.last              = rsp_last_ff;

   a_age_in_pass: assert property (@(posedge clock) disable iff (reset)
      state_ff == rsmp2_pkg::ST_MAC |-> age_ff <= last_age)
      else $error("tap counter ran past the end of the pass");

   a_drain_then_out: assert property (@(posedge clock) disable iff (reset)
      state_ff == rsmp2_pkg::ST_DRAIN |=> state_ff == rsmp2_pkg::ST_OUT && !part_done_ff)
      else $error("accumulator drain not followed by output");

   a_decim_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_interp_ff |-> rsp_last_ff && !rsp_phase_ff)
      else $error("decimator response with wrong phase or last flag");

   a_phase1_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_phase_ff |-> rsp_interp_ff && rsp_last_ff)
      else $error("odd phase response not marked last");

   a_ring_index: assert property (@(posedge clock) disable iff (reset)
      state_ff == rsmp2_pkg::ST_MAC |-> rd_idx_ff <= LAST_POS && digit_ff <= LAST_DIG)
      else $error("ring index or digit counter out of range");

endmodule

// File: design/rsmp2_ram.sv
// Simple dual-port RAM with one write port and a registered read port.
module rsmp2_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 65,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
